// ===== hw/rtl/aalr_pkg.sv =====
`timescale 1ns / 1ps

package aalr_pkg;

  // Fixed field widths of the item and result channels.
  localparam int COORD_BITS = 12;
  localparam int PIX_BITS   = COORD_BITS + 1;
  localparam int COV_BITS   = 8;

  // Coverage for an endpoint pixel: half of full scale, rounded up.
  localparam logic [COV_BITS-1:0] COV_HALF = 8'd128;
  localparam logic [COV_BITS-1:0] COV_NONE = 8'd0;
  localparam logic [COV_BITS-1:0] COV_FULL = 8'd255;

  // Result index within one run.
  localparam logic [1:0] LAST_START_IDX = 2'd3;
  localparam logic [1:0] LAST_STEP_IDX  = 2'd1;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORDER,
    S_DIV,
    S_FINAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t                   operation;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
    logic [COV_BITS-1:0] coverage;
    logic                last_of_run;
    logic                line_done;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       step;
    logic       order;
    logic       div_step;
    logic       finalize;
    logic       emit;
    logic       emit_start;
    logic [1:0] emit_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic line_active;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/aalr_ctrl.sv =====
`timescale 1ns / 1ps

module aalr_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  aalr_pkg::op_t     op,
  input  aalr_pkg::status_t status,
  output aalr_pkg::cmd_t    cmd
);

  localparam int DIV_ITERS = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_ITERS + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_ITERS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  aalr_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       idx, idx_next;
  logic             run_start, run_start_next;
  logic             accept;
  logic             last_idx;

  assign accept   = item_valid && item_ready;
  assign last_idx = run_start ? (idx == aalr_pkg::LAST_START_IDX)
                              : (idx == aalr_pkg::LAST_STEP_IDX);

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aalr_pkg::S_IDLE;
      cnt       <= '0;
      idx       <= '0;
      run_start <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      idx       <= idx_next;
      run_start <= run_start_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = idx;
    run_start_next = run_start;
    item_ready     = 1'b0;
    cmd            = '0;
    cmd.emit_start = run_start;
    cmd.emit_idx   = idx;
    unique case (state)
      aalr_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (accept) begin
          if (op == aalr_pkg::OP_START) begin
            cmd.capture = 1'b1;
            state_next  = aalr_pkg::S_ORDER;
          end else if (status.line_active) begin
            cmd.step       = 1'b1;
            idx_next       = '0;
            run_start_next = 1'b0;
            state_next     = aalr_pkg::S_EMIT;
          end
        end
      end
      aalr_pkg::S_ORDER: begin
        cmd.order  = 1'b1;
        cnt_next   = CNT_LOAD;
        state_next = aalr_pkg::S_DIV;
      end
      aalr_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - CNT_ONE;
        if (cnt == CNT_ONE) begin
          state_next = aalr_pkg::S_FINAL;
        end
      end
      aalr_pkg::S_FINAL: begin
        cmd.finalize   = 1'b1;
        idx_next       = '0;
        run_start_next = 1'b1;
        state_next     = aalr_pkg::S_EMIT;
      end
      aalr_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          idx_next = idx + 2'd1;
          if (last_idx) begin
            state_next = aalr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = aalr_pkg::S_IDLE;
      end
    endcase
  end

  // The divider always runs its full count before the result is formed.
  assert property (@(posedge clk) disable iff (rst)
    state == aalr_pkg::S_ORDER |=> state == aalr_pkg::S_DIV && cnt == CNT_LOAD)
    else $error("divider did not start with a full iteration count");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finalize |-> $past(state) == aalr_pkg::S_DIV && $past(cnt) == CNT_ONE)
    else $error("gradient formed before the divider finished");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result loaded over a pending transfer");

endmodule

// ===== hw/rtl/aalr_dp.sv =====
`timescale 1ns / 1ps

module aalr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  aalr_pkg::item_t   item,
  input  aalr_pkg::cmd_t    cmd,
  output aalr_pkg::status_t status,
  output logic              result_valid,
  input  logic              result_ready,
  output aalr_pkg::result_t result
);

  localparam int CB      = aalr_pkg::COORD_BITS;
  localparam int PB      = aalr_pkg::PIX_BITS;
  localparam int CV      = aalr_pkg::COV_BITS;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int SLOPE_W = FRAC_BITS + 2;
  localparam int ACC_W   = PB + FRAC_BITS;

  // Captured endpoints of a start item.
  logic [CB-1:0] raw_x0, raw_y0, raw_x1, raw_y1;

  // Ordered endpoints along the major axis and divider state.
  logic [CB-1:0] a0, b0, a1, b1;
  logic [CB-1:0] dmaj;
  logic          dmin_neg;
  logic [CB:0]   rem;
  logic [Q_W-1:0] quot;

  // Line state.
  logic               steep_flag;
  logic [PB-1:0]      major_position;
  logic [PB-1:0]      major_limit;
  logic [ACC_W-1:0]   intercept_accum;
  logic [SLOPE_W-1:0] slope;
  logic               line_active;

  // Values latched for the two results of a step.
  logic [PB-1:0] step_maj;
  logic [PB-1:0] step_ip;
  logic [CV-1:0] step_f;

  // Axis selection and endpoint ordering from the captured coordinates.
  logic [CB-1:0] adx, ady, m0, n0, m1, n1;
  logic          steep_c, swap_c;
  logic [CB-1:0] oa0, ob0, oa1, ob1;

  always_comb begin
    adx     = (raw_x1 > raw_x0) ? raw_x1 - raw_x0 : raw_x0 - raw_x1;
    ady     = (raw_y1 > raw_y0) ? raw_y1 - raw_y0 : raw_y0 - raw_y1;
    steep_c = ady > adx;
    m0      = steep_c ? raw_y0 : raw_x0;
    n0      = steep_c ? raw_x0 : raw_y0;
    m1      = steep_c ? raw_y1 : raw_x1;
    n1      = steep_c ? raw_x1 : raw_y1;
    swap_c  = m1 < m0;
    oa0     = swap_c ? m1 : m0;
    ob0     = swap_c ? n1 : n0;
    oa1     = swap_c ? m0 : m1;
    ob1     = swap_c ? n0 : n1;
  end

  // One restoring division step: one quotient bit per cycle.
  logic          div_ge;
  logic [CB:0]   div_diff;
  logic [CB:0]   div_base;

  always_comb begin
    div_ge   = rem >= {1'b0, dmaj};
    div_diff = rem - {1'b0, dmaj};
    div_base = div_ge ? div_diff : rem;
  end

  // Signed gradient and first interior intercept.
  logic [SLOPE_W-1:0] q_ext, grad;
  logic [ACC_W-1:0]   icpt_first;
  logic [PB-1:0]      a0_next;

  always_comb begin
    q_ext      = {1'b0, quot};
    if (dmaj == '0) begin
      grad = '0;
    end else if (dmin_neg) begin
      grad = -q_ext;
    end else begin
      grad = q_ext;
    end
    icpt_first = {1'b0, b0, {FRAC_BITS{1'b0}}}
               + {{(ACC_W - SLOPE_W){grad[SLOPE_W-1]}}, grad};
    a0_next    = {1'b0, a0} + PB'(1);
  end

  // Interior step update.
  logic [PB-1:0]    mp_next;
  logic [ACC_W-1:0] acc_next;

  always_comb begin
    mp_next  = major_position + PB'(1);
    acc_next = intercept_accum + {{(ACC_W - SLOPE_W){slope[SLOPE_W-1]}}, slope};
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      steep_flag      <= 1'b0;
      major_position  <= '0;
      major_limit     <= '0;
      intercept_accum <= '0;
      slope           <= '0;
      line_active     <= 1'b0;
    end else begin
      if (cmd.order) begin
        steep_flag <= steep_c;
      end
      if (cmd.finalize) begin
        slope           <= grad;
        intercept_accum <= icpt_first;
        major_position  <= a0_next;
        major_limit     <= {1'b0, a1};
        line_active     <= a0_next < {1'b0, a1};
      end
      if (cmd.step) begin
        major_position  <= mp_next;
        intercept_accum <= acc_next;
        if (mp_next >= major_limit) begin
          line_active <= 1'b0;
        end
      end
    end
  end

  // Payload registers with no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_x0 <= item.start_x;
      raw_y0 <= item.start_y;
      raw_x1 <= item.end_x;
      raw_y1 <= item.end_y;
    end
    if (cmd.order) begin
      a0       <= oa0;
      b0       <= ob0;
      a1       <= oa1;
      b1       <= ob1;
      dmaj     <= oa1 - oa0;
      dmin_neg <= ob1 < ob0;
      rem      <= {1'b0, (ob1 < ob0) ? ob0 - ob1 : ob1 - ob0};
      quot     <= '0;
    end
    if (cmd.div_step) begin
      rem  <= {div_base[CB-1:0], 1'b0};
      quot <= {quot[Q_W-2:0], div_ge};
    end
    if (cmd.step) begin
      step_maj <= major_position;
      step_ip  <= intercept_accum[ACC_W-1:FRAC_BITS];
      step_f   <= intercept_accum[FRAC_BITS-1 -: CV];
    end
  end

  // Result selection for the current index of the run.
  logic [PB-1:0] sel_maj, sel_min;
  logic [CV-1:0] sel_cov;
  logic          sel_last;
  aalr_pkg::result_t res_c;

  always_comb begin
    if (cmd.emit_start) begin
      sel_maj  = {1'b0, cmd.emit_idx[1] ? a1 : a0};
      sel_min  = {1'b0, cmd.emit_idx[1] ? b1 : b0} + PB'(cmd.emit_idx[0]);
      sel_cov  = cmd.emit_idx[0] ? aalr_pkg::COV_NONE : aalr_pkg::COV_HALF;
      sel_last = cmd.emit_idx == aalr_pkg::LAST_START_IDX;
    end else begin
      sel_maj  = step_maj;
      sel_min  = step_ip + PB'(cmd.emit_idx[0]);
      sel_cov  = cmd.emit_idx[0] ? step_f : aalr_pkg::COV_FULL - step_f;
      sel_last = cmd.emit_idx == aalr_pkg::LAST_STEP_IDX;
    end
    res_c.pixel_x     = steep_flag ? sel_min : sel_maj;
    res_c.pixel_y     = steep_flag ? sel_maj : sel_min;
    res_c.coverage    = sel_cov;
    res_c.last_of_run = sel_last;
    res_c.line_done   = !line_active;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= res_c;
    end
  end

  assign status.line_active = line_active;
  assign status.out_free    = !result_valid || result_ready;

  // Interior columns only open when a new line is set up.
  assert property (@(posedge clk) disable iff (rst)
    $rose(line_active) |-> $past(cmd.finalize))
    else $error("line became active without a start");

endmodule

// ===== hw/rtl/antialiased_line_raster_core.sv =====
`timescale 1ns / 1ps

// Anti-aliased line rasterizer. A start transfer carries both endpoints and
// produces four results, the two pixel pairs of the endpoints; each step
// transfer on an open line then produces the two pixels of the next interior
// column, weighted from the fraction of the running intercept. The results
// go to the output register, which takes a new result every cycle it is
// drained. A start orders the endpoints, then the restoring divider forms the
// gradient one quotient bit per cycle, then the first intercept is formed. A
// new item is accepted while the last result of the previous one still waits
// in the output register.
module antialiased_line_raster_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  aalr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output aalr_pkg::result_t result
);

  aalr_pkg::cmd_t    cmd;
  aalr_pkg::status_t status;

  // Sequencer for start and step items.
  aalr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (item.operation),
    .status     (status),
    .cmd        (cmd)
  );

  // Endpoint ordering, gradient divider, line state and output register.
  aalr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== tb/antialiased_line_raster_checker.sv =====
`timescale 1ns / 1ps

// Watches the item and result channels of the line rasterizer. Every accepted
// item is rasterized here into the pixels it must produce, and every accepted
// result is compared with the oldest pixel still due.
module antialiased_line_raster_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  aalr_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  aalr_pkg::result_t result,
  output int                mismatches,
  output int                pixels_pending
);

  localparam int FRAC  = 16;
  localparam int PB    = aalr_pkg::PIX_BITS;
  localparam int CV    = aalr_pkg::COV_BITS;
  localparam int IBITS = PB + FRAC;
  localparam int GBITS = FRAC + 2;

  // Line state: axis swap, next interior column, end column, intercept, slope.
  logic                       steep;
  logic [PB-1:0]              major_pos;
  logic [PB-1:0]              major_end;
  logic [IBITS-1:0]           intercept;
  logic signed [GBITS-1:0]    gradient;
  logic                       line_open;
  aalr_pkg::result_t          pixels_due[$];
  aalr_pkg::result_t          due;

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Queues one pixel given in major/minor terms, mapped back to x/y.
  function automatic void queue_pixel(logic [PB-1:0] maj, logic [PB-1:0] mnr,
                                      logic [CV-1:0] cov, logic last, logic done);
    aalr_pkg::result_t r;
    r.pixel_x     = steep ? mnr : maj;
    r.pixel_y     = steep ? maj : mnr;
    r.coverage    = cov;
    r.last_of_run = last;
    r.line_done   = done;
    pixels_due.push_back(r);
  endfunction

  // Updates the line state for one item and queues the pixels it produces.
  function automatic void rasterize(aalr_pkg::item_t it);
    int x0, y0, x1, y1, adx, ady, a0, b0, a1, b1, tmp, dmin;
    longint q;
    logic done;
    logic [PB-1:0] maj, whole;
    logic [CV-1:0] frac;
    if (it.operation == aalr_pkg::OP_START) begin
      x0 = int'(it.start_x);
      y0 = int'(it.start_y);
      x1 = int'(it.end_x);
      y1 = int'(it.end_y);
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      // Equal deltas stay on the x axis.
      steep = (ady > adx);
      if (steep) begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      if (a1 < a0) begin
        tmp = a0; a0 = a1; a1 = tmp;
        tmp = b0; b0 = b1; b1 = tmp;
      end
      dmin = b1 - b0;
      // Gradient truncated toward zero; a zero-length line gets a flat one.
      if (a1 == a0) begin
        q = 0;
      end else begin
        q = (longint'(dmin < 0 ? -dmin : dmin) << FRAC) / (a1 - a0);
        if (dmin < 0) q = -q;
      end
      gradient  = GBITS'(q);
      intercept = IBITS'((longint'(b0) << FRAC) + q);
      major_pos = PB'(a0 + 1);
      major_end = PB'(a1);
      line_open = (a0 + 1 < a1);
      done      = !line_open;
      queue_pixel(PB'(a0), PB'(b0), aalr_pkg::COV_HALF, 1'b0, done);
      queue_pixel(PB'(a0), PB'(b0 + 1), aalr_pkg::COV_NONE, 1'b0, done);
      queue_pixel(PB'(a1), PB'(b1), aalr_pkg::COV_HALF, 1'b0, done);
      queue_pixel(PB'(a1), PB'(b1 + 1), aalr_pkg::COV_NONE, 1'b1, done);
    end else if (line_open) begin
      // Interior column: weights come from the top fraction bits.
      maj       = major_pos;
      whole     = intercept[IBITS-1:FRAC];
      frac      = intercept[FRAC-1 -: CV];
      major_pos = major_pos + 1'b1;
      intercept = intercept + IBITS'(longint'(gradient));
      if (major_pos >= major_end) line_open = 1'b0;
      done = !line_open;
      queue_pixel(maj, whole, aalr_pkg::COV_FULL - frac, 1'b0, done);
      queue_pixel(maj, whole + 1'b1, frac, 1'b1, done);
    end
  endfunction

  // Compare each result transfer first, then account for a new item transfer.
  always @(posedge clk) begin
    if (rst) begin
      steep     = 1'b0;
      major_pos = '0;
      major_end = '0;
      intercept = '0;
      gradient  = '0;
      line_open = 1'b0;
      pixels_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (pixels_due.size() == 0) begin
          flag_mismatch("unexpected result, pixel_x", result.pixel_x, -1);
        end else begin
          due = pixels_due.pop_front();
          if (result.pixel_x !== due.pixel_x)
            flag_mismatch("pixel_x", result.pixel_x, due.pixel_x);
          if (result.pixel_y !== due.pixel_y)
            flag_mismatch("pixel_y", result.pixel_y, due.pixel_y);
          if (result.coverage !== due.coverage)
            flag_mismatch("coverage", result.coverage, due.coverage);
          if (result.last_of_run !== due.last_of_run)
            flag_mismatch("last_of_run", result.last_of_run, due.last_of_run);
          if (result.line_done !== due.line_done)
            flag_mismatch("line_done", result.line_done, due.line_done);
        end
      end
      if (item_valid && item_ready) rasterize(item);
    end
    pixels_pending <= pixels_due.size();
  end

endmodule

// ===== tb/antialiased_line_raster_core_tb.sv =====
`timescale 1ns / 1ps

module antialiased_line_raster_core_tb;

  localparam int ITEM_GOAL = 320;
  localparam int CB        = aalr_pkg::COORD_BITS;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  aalr_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  aalr_pkg::result_t result;
  int                mismatches;
  int                pixels_pending;

  // Items that make the block work, and interior columns left on the open line.
  int      counted;
  int      steps_left;
  int      results_taken;
  logic    send_quiet;
  logic    take_quiet;

  antialiased_line_raster_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  antialiased_line_raster_checker line_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatches     (mismatches),
    .pixels_pending (pixels_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("antialiased_line_raster_core_tb NOT OK");
    $finish;
  end

  // Offers one item after a random gap and returns at the edge of its transfer.
  task automatic offer(aalr_pkg::item_t it);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic start_line(int x0, int y0, int x1, int y1);
    aalr_pkg::item_t it;
    int dx, dy;
    it.operation = aalr_pkg::OP_START;
    it.start_x   = CB'(x0);
    it.start_y   = CB'(y0);
    it.end_x     = CB'(x1);
    it.end_y     = CB'(y1);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    steps_left = ((dx > dy) ? dx : dy) - 1;
    if (steps_left < 0) steps_left = 0;
    offer(it);
    counted++;
  endtask

  // Step payload carries random coordinates, which the block must ignore.
  task automatic step_line();
    aalr_pkg::item_t it;
    it.operation = aalr_pkg::OP_STEP;
    it.start_x   = CB'($urandom_range(0, 4095));
    it.start_y   = CB'($urandom_range(0, 4095));
    it.end_x     = CB'($urandom_range(0, 4095));
    it.end_y     = CB'($urandom_range(0, 4095));
    offer(it);
    if (steps_left > 0) begin
      steps_left--;
      counted++;
    end
  endtask

  // Holds the item channel idle until every pixel due has come back.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
  endtask

  // Coordinates lean toward both borders of the range.
  function automatic int any_coord();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(4092, 4095);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int nudge(int c, int span);
    int v;
    v = $urandom_range(0, 1) ? c + $urandom_range(0, span) : c - $urandom_range(0, span);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int stall;
    take_quiet    = 1'b0;
    results_taken = 0;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (results_taken == 60) begin
        result_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = take_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      results_taken++;
      if ($urandom_range(0, 29) == 0) take_quiet = !take_quiet;
    end
  end

  // Item side: directed lines first, then random short lines walked to the end.
  initial begin
    int x0, y0, x1, y1, span, n, pick;
    logic paused;
    send_quiet = 1'b0;
    paused     = 1'b0;
    counted    = 0;
    steps_left = 0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Step before any line, zero length, full diagonal, reversed and falling.
    step_line();
    start_line(0, 0, 0, 0);
    start_line(0, 0, 4095, 4095);
    step_line();
    start_line(4095, 4095, 0, 0);
    start_line(0, 4095, 4095, 0);
    step_line();
    // Steep line, then adjacent endpoints followed by a step with no line open.
    start_line(5, 0, 7, 4095);
    step_line();
    start_line(10, 10, 11, 10);
    step_line();
    // One interior column, then a spare step.
    start_line(10, 10, 12, 11);
    step_line();
    step_line();
    // Minor coordinate plus one reaches past the coordinate range.
    start_line(0, 4095, 3, 4095);
    step_line();
    start_line(4095, 0, 4095, 3);
    step_line();
    // Short steep falling line walked to its end and one step beyond.
    start_line(100, 200, 97, 205);
    repeat (5) step_line();

    while (counted < ITEM_GOAL) begin
      if (counted >= 170 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      x0 = any_coord();
      y0 = any_coord();
      if (pick == 0) begin
        step_line();
      end else if (pick == 1) begin
        // Long line across the range with only a few columns walked.
        start_line(x0, y0, any_coord(), any_coord());
        repeat ($urandom_range(0, 4)) step_line();
      end else begin
        span = $urandom_range(0, 16);
        x1 = nudge(x0, span);
        y1 = nudge(y0, span);
        start_line(x0, y0, x1, y1);
        // Mostly complete walks, some cut short, some with extra steps.
        pick = $urandom_range(0, 5);
        if (pick == 0) n = $urandom_range(0, steps_left);
        else if (pick == 1) n = steps_left + $urandom_range(1, 2);
        else n = steps_left;
        repeat (n) step_line();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("antialiased_line_raster_core_tb OK");
    end else begin
      $display("antialiased_line_raster_core_tb NOT OK");
    end
    $finish;
  end

endmodule
